// ----- design/msbsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbsc_pkg
// Shared types, fixed-point constants and the tanh table generator for the
// stereo mix bus soft clipper.
// ----------------------------------------------------------------------------
package msbsc_pkg;

  localparam int unsigned ContribW = 18;   // |contribution| <= 2^16

  localparam logic [15:0] OneQ14   = 16'd16384;
  localparam logic [15:0] GainMax  = 16'd32768;
  localparam logic [15:0] KneeQ15  = 16'd31130;
  localparam logic [15:0] HeadQ15  = 16'd1638;
  localparam logic [4:0]  Drive    = 5'd20;
  // past this distance above the knee the table index is saturated anyway
  localparam logic [13:0] DiffMax  = 14'd16383;

  localparam logic [63:0] Q30One   = 64'd1 << 30;

  typedef struct packed {
    logic vld;
    logic last;
  } beat_ctrl_t;

  // Unsigned quotient by restoring long division; elaboration only.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One table entry, Q.15. step is the Q.30 spacing of the table points.
  // Runs at elaboration only: tanh by repeated use of the addition theorem.
  function automatic logic [15:0] tanh_entry(logic [63:0] step, int unsigned idx);
    logic [63:0] h2;
    logic [63:0] h3;
    logic [63:0] h5;
    logic [63:0] h7;
    logic [63:0] t1;
    logic [63:0] t;
    logic [63:0] den;
    h2 = (step * step) >> 30;
    h3 = (h2 * step) >> 30;
    h5 = (h3 * h2) >> 30;
    h7 = (h5 * h2) >> 30;
    t1 = step - h3 / 64'd3 + (64'd2 * h5) / 64'd15 - (64'd17 * h7) / 64'd315;
    t  = 64'd0;
    for (int unsigned i = 0; i < idx; i++) begin
      den = Q30One + ((t * t1) >> 30);
      t   = udiv64((t + t1) << 30, den);
    end
    return 16'((t + (64'd1 << 14)) >> 15);
  endfunction

endpackage

// ----- design/msbsc_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbsc_mac
// One channel lane: sample x gain x pan gain, then a saturating accumulate.
// ----------------------------------------------------------------------------
module msbsc_mac #(
  parameter int unsigned ACC_WIDTH = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  msbsc_pkg::beat_ctrl_t        ctrl_i,
  input  logic signed [15:0]           sample_i,
  input  logic [15:0]                  gain_i,
  input  logic [15:0]                  pan_gain_i,
  output logic                         vld_o,
  output logic signed [ACC_WIDTH-1:0]  sum_o
);

  localparam int unsigned ExtW = ACC_WIDTH + 1;
  localparam int unsigned PadW = ExtW - msbsc_pkg::ContribW;

  msbsc_pkg::beat_ctrl_t ctrl1_q, ctrl2_q;
  logic                  vld3_q;

  logic signed [32:0] prod1_d, prod1_q;
  logic [15:0]        pg1_q;
  logic signed [18:0] scaled_w;
  logic signed [35:0] prod2_d, prod2_q;
  logic signed [17:0] contrib_w;

  logic signed [ACC_WIDTH-1:0] acc_q, acc_d, sat_w, sum_q;
  logic signed [ExtW-1:0]      add_w;

  assign prod1_d   = sample_i * $signed({1'b0, gain_i});
  assign scaled_w  = prod1_q[32:14];                       // floor(/2^14)
  assign prod2_d   = scaled_w * $signed({1'b0, pg1_q});
  assign contrib_w = prod2_q[31:14];

  assign add_w = {acc_q[ACC_WIDTH-1], acc_q} + {{PadW{contrib_w[17]}}, contrib_w};

  always_comb begin
    if (add_w[ExtW-1] != add_w[ExtW-2]) begin
      sat_w = add_w[ExtW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                            : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sat_w = add_w[ACC_WIDTH-1:0];
    end
    acc_d = acc_q;
    if (ctrl2_q.vld) begin
      acc_d = ctrl2_q.last ? '0 : sat_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      vld3_q  <= 1'b0;
      acc_q   <= '0;
    end else if (en_i) begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      vld3_q  <= ctrl2_q.vld & ctrl2_q.last;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      pg1_q   <= pan_gain_i;
      prod2_q <= prod2_d;
      sum_q   <= sat_w;
    end
  end

  assign vld_o = vld3_q;
  assign sum_o = sum_q;

endmodule

// ----- design/msbsc_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbsc_clip
// Tanh soft clipper for one lane: index, table read, shape and sign.
// ----------------------------------------------------------------------------
module msbsc_clip #(
  parameter int unsigned ACC_WIDTH    = 24,
  parameter int unsigned TANH_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic signed [ACC_WIDTH-1:0]  sum_i,
  output logic                         vld_o,
  output logic [15:0]                  mixed_o
);

  localparam int unsigned IdxW     = (TANH_ENTRIES > 1) ? $clog2(TANH_ENTRIES) : 1;
  localparam logic [63:0] TanhStep = (64'd1 << 33) / TANH_ENTRIES;
  localparam logic [13:0] IdxMax   = 14'(TANH_ENTRIES - 1);

  logic [15:0] rom_w [TANH_ENTRIES];

  for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_rom
    localparam logic [15:0] Entry = msbsc_pkg::tanh_entry(TanhStep, g);
    assign rom_w[g] = Entry;
  end

  // index stage
  logic [ACC_WIDTH-1:0] mag_w, diff_w;
  logic [13:0]          diff_c;
  logic [18:0]          over_w;
  logic [31:0]          scaled_w;
  logic [13:0]          idx_full, idx_sat;

  assign mag_w    = sum_i[ACC_WIDTH-1] ? (~sum_i + 1'b1) : sum_i;
  assign diff_w   = mag_w - ACC_WIDTH'(msbsc_pkg::KneeQ15);
  assign diff_c   = (diff_w > ACC_WIDTH'(msbsc_pkg::DiffMax)) ? msbsc_pkg::DiffMax
                                                             : diff_w[13:0];
  assign over_w   = 19'(diff_c) * 19'(msbsc_pkg::Drive);
  assign scaled_w = 32'(over_w) * 32'(TANH_ENTRIES);
  assign idx_full = scaled_w[31:18];
  assign idx_sat  = (idx_full > IdxMax) ? IdxMax : idx_full;

  logic            vld_a_q, vld_b_q, vld_c_q;
  logic            neg_a_q, neg_b_q, over_a_q, over_b_q;
  logic [15:0]     pass_a_q, pass_b_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0]     tanh_q;
  logic [15:0]     out_q;

  // shaping stage
  logic [26:0] head_w;
  logic [15:0] shaped_w, pos_w, res_w;

  assign head_w   = 27'(msbsc_pkg::HeadQ15) * 27'(tanh_q) + 27'd16384;
  assign shaped_w = msbsc_pkg::KneeQ15 + 16'(head_w >> 15);
  assign pos_w    = shaped_w[15] ? 16'd32767 : shaped_w;

  always_comb begin
    if (!over_b_q) begin
      res_w = pass_b_q;
    end else if (neg_b_q) begin
      res_w = ~shaped_w + 16'd1;
    end else begin
      res_w = pos_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q  <= sum_i[ACC_WIDTH-1];
      over_a_q <= mag_w > ACC_WIDTH'(msbsc_pkg::KneeQ15);
      pass_a_q <= sum_i[15:0];
      idx_q    <= idx_sat[IdxW-1:0];
      neg_b_q  <= neg_a_q;
      over_b_q <= over_a_q;
      pass_b_q <= pass_a_q;
      tanh_q   <= rom_w[idx_q];
      out_q    <= res_w;
    end
  end

  assign vld_o   = vld_c_q;
  assign mixed_o = out_q;

endmodule

// ----- design/msbsc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbsc_merge
// Joins the two lane results into one output beat and holds it for the sink.
// ----------------------------------------------------------------------------
module msbsc_merge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_l_i,
  input  logic        vld_r_i,
  input  logic [15:0] mixed_l_i,
  input  logic [15:0] mixed_r_i,
  output logic        en_o,
  output logic        tvalid_o,
  input  logic        tready_i,
  output logic [31:0] tdata_o
);

  logic        valid_q;
  logic [31:0] data_q;
  logic        res_vld;

  // lanes run in lock step; both must agree
  assign res_vld = vld_l_i & vld_r_i;
  // hold the pipe only when a result has nowhere to go
  assign en_o    = !(res_vld && valid_q && !tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_vld && en_o) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && en_o) begin
      data_q <= {mixed_r_i, mixed_l_i};
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;

endmodule

// ----- design/stereo_mix_bus_soft_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_mix_bus_soft_clip
// Stereo mix bus: per-source gain and balance pan into saturating sums,
// tanh soft clip of both sums on the last source of a frame.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                       Per beat
//  s_axis    in   tdata: left, right, gain, pan; tlast: last    one source
//  m_axis    out  tdata: mixed left, mixed right                one frame
//
//  One source beat is taken every cycle unless stalled; the multiply and
//  accumulate lanes are fully pipelined, the accumulate add sets the rate.
//  After its tlast beat a frame result crosses the product, sum, clipper
//  and output registers. Reset clears the sums and all valid flags; the
//  tanh table is constant. s_axis stalls only while one result waits in
//  the output register and the next one has reached the end of the
//  clipper with m_axis stalled.
module stereo_mix_bus_soft_clip #(
  parameter int unsigned ACC_WIDTH    = 24,
  parameter int unsigned TANH_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // source beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] source_left, [31:16] source_right, [47:32] clip_gain,
  // [63:48] pan_position
  input  logic [63:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,    // last_source
  // frame results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] mixed_left, [31:16] mixed_right
  output logic [31:0] m_axis_tdata_o
);

  logic               en;
  logic signed [15:0] src_l, src_r, pan;
  logic [15:0]        gain_raw, gain_c, pg_l, pg_r;
  msbsc_pkg::beat_ctrl_t in_ctrl;

  assign src_l    = s_axis_tdata_i[15:0];
  assign src_r    = s_axis_tdata_i[31:16];
  assign gain_raw = s_axis_tdata_i[47:32];
  assign pan      = s_axis_tdata_i[63:48];

  // gain saturates at 2.0
  assign gain_c = (gain_raw > msbsc_pkg::GainMax) ? msbsc_pkg::GainMax : gain_raw;

  // balance pan: the side being panned towards stays at unity, the other
  // side falls off linearly; pan beyond full gives zero on the far side
  always_comb begin
    if (pan >= $signed(msbsc_pkg::OneQ14)) begin
      pg_l = '0;
    end else if (pan <= 0) begin
      pg_l = msbsc_pkg::OneQ14;
    end else begin
      pg_l = msbsc_pkg::OneQ14 - pan;
    end
    if (pan <= -$signed(msbsc_pkg::OneQ14)) begin
      pg_r = '0;
    end else if (pan >= 0) begin
      pg_r = msbsc_pkg::OneQ14;
    end else begin
      pg_r = msbsc_pkg::OneQ14 + pan;
    end
  end

  assign s_axis_tready_o = en;
  assign in_ctrl.vld     = s_axis_tvalid_i;
  assign in_ctrl.last    = s_axis_tlast_i;

  // --- lanes ---------------------------------------------------------------
  logic                        mac_vld_l, mac_vld_r;
  logic signed [ACC_WIDTH-1:0] sum_l, sum_r;
  logic                        clip_vld_l, clip_vld_r;
  logic [15:0]                 mixed_l, mixed_r;

  msbsc_mac #(.ACC_WIDTH(ACC_WIDTH)) u_mac_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctrl_i     (in_ctrl),
    .sample_i   (src_l),
    .gain_i     (gain_c),
    .pan_gain_i (pg_l),
    .vld_o      (mac_vld_l),
    .sum_o      (sum_l)
  );

  msbsc_mac #(.ACC_WIDTH(ACC_WIDTH)) u_mac_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctrl_i     (in_ctrl),
    .sample_i   (src_r),
    .gain_i     (gain_c),
    .pan_gain_i (pg_r),
    .vld_o      (mac_vld_r),
    .sum_o      (sum_r)
  );

  msbsc_clip #(.ACC_WIDTH(ACC_WIDTH), .TANH_ENTRIES(TANH_ENTRIES)) u_clip_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (mac_vld_l),
    .sum_i   (sum_l),
    .vld_o   (clip_vld_l),
    .mixed_o (mixed_l)
  );

  msbsc_clip #(.ACC_WIDTH(ACC_WIDTH), .TANH_ENTRIES(TANH_ENTRIES)) u_clip_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (mac_vld_r),
    .sum_i   (sum_r),
    .vld_o   (clip_vld_r),
    .mixed_o (mixed_r)
  );

  // --- merge and output register -------------------------------------------
  msbsc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_l_i   (clip_vld_l),
    .vld_r_i   (clip_vld_r),
    .mixed_l_i (mixed_l),
    .mixed_r_i (mixed_r),
    .en_o      (en),
    .tvalid_o  (m_axis_tvalid_o),
    .tready_i  (m_axis_tready_i),
    .tdata_o   (m_axis_tdata_o)
  );

  // --- checks --------------------------------------------------------------
  // both lanes carry the same beats at the accumulator and clipper outputs
  a_lanes_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_vld_l == mac_vld_r) && (clip_vld_l == clip_vld_r))
    else $error("lanes out of step");

  // a result stuck behind a full output register keeps its value
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clip_vld_l && m_axis_tvalid_o && !m_axis_tready_i)
    |=> (clip_vld_l && $stable(mixed_l) && $stable(mixed_r)))
    else $error("stalled clipper result changed");

  // an output beat only ever comes from a finished clipper result
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(clip_vld_l))
    else $error("output beat without a clipper result");

endmodule
